// File: rtl/core/usvt_pkg.sv
// Shared constants and codes for the unique value set table.
package usvt_pkg;

  localparam int unsigned DEF_STORE_DEPTH = 64;

  localparam int unsigned VAL_W   = 32;
  localparam int unsigned LIMIT_W = 7;
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned COUNT_W = 7;

  // Operation codes on func.
  localparam logic FUNC_ADD    = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  localparam logic [LIMIT_W-1:0] CAPACITY_RESET = LIMIT_W'(64);

endpackage

// File: rtl/core/unique_value_set_table_top.sv
// Top level of the unique value set table: store, scan sequencer and result register.
// Keeps a set of distinct 32-bit values in a store that fills from slot 0.
// Each input beat is an add (func 0) or a lookup (func 1) and yields one
// result beat. The stored values are held in a memory with one read port,
// read one slot per cycle and checked against the item by one comparator,
// in slot order, so the first match gives the slot. When the value is
// absent, every stored slot is read; the item then passes the append step
// and the result step, where the result is loaded once the output register
// is free. A match stops the scan early and the result comes sooner. The
// next input beat can be taken in the cycle after the result is loaded. The
// memory read port and the single comparator set the pace. An add is appended
// in the cycle after the scan, only when the value is absent and the count is
// below the smaller of capacity_limit and STORE_DEPTH. in_stall is high while
// an item is in work; a finished result sits in the output register, so a new
// item may be taken while the previous result waits, and only the hand-over of
// the next result waits on out_stall. Lowering the capacity limit below the
// count keeps the held values and reads as full. The user must write the
// capacity register only while the block is idle; the block does not enforce
// this. cfg_ready is always high. The store needs no clearing: only slots below
// the count are ever read, and each was written by an add.
module unique_value_set_table_top
  import usvt_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = DEF_STORE_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  // configuration: capacity limit
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [LIMIT_W-1:0]       cfg_data,
  // input beats
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     func,
  input  logic signed [VAL_W-1:0]  element_value,
  // result beats
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     added,
  output logic                     present,
  output logic [SLOT_W-1:0]        slot_index,
  output logic [COUNT_W-1:0]       member_count,
  output logic                     is_full,
  output logic                     is_empty
);

  localparam int unsigned CW = $clog2(STORE_DEPTH + 1);
  localparam int unsigned AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned LW = (CW > LIMIT_W) ? CW : LIMIT_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]          state, state_next;
  logic [LIMIT_W-1:0]  capacity_limit;
  logic [CW-1:0]       fill_count;

  // item in work
  logic                op;
  logic [VAL_W-1:0]    val;
  logic [CW-1:0]       scan_cnt;
  logic [CW-1:0]       addr_cnt;
  logic                rd_vld;
  logic [CW-1:0]       rd_slot;
  logic [VAL_W-1:0]    rd_data;
  logic                found;
  logic [CW-1:0]       slot;
  logic                add_ok;
  // remembers whether the append went through
  logic                add_ok_done;

  logic [VAL_W-1:0]    value_store [STORE_DEPTH];

  logic                in_acc, out_free;
  logic                issue, hit_now;
  logic [LW-1:0]       eff_limit;
  logic                full_pre, full_post;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // effective limit: smaller of the register and the store depth
  always_comb begin
    if (LW'(capacity_limit) >= LW'(STORE_DEPTH)) begin
      eff_limit = LW'(STORE_DEPTH);
    end else begin
      eff_limit = LW'(capacity_limit);
    end
  end

  assign full_pre  = LW'(fill_count) >= eff_limit;
  assign full_post = LW'(fill_count) >= eff_limit;

  assign issue   = (state == ST_SCAN) && (addr_cnt < scan_cnt) && !hit_now;
  assign hit_now = (state == ST_SCAN) && rd_vld && (rd_data == val);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit_now || (addr_cnt == scan_cnt)) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      capacity_limit <= CAPACITY_RESET;
      fill_count     <= '0;
      rd_vld         <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= issue;
      if (cfg_valid && cfg_ready) begin
        capacity_limit <= cfg_data;
      end
      if (state == ST_FIN && add_ok) begin
        fill_count <= fill_count + CW'(1);
      end
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // scan datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op       <= func;
      val      <= element_value;
      scan_cnt <= fill_count;
      addr_cnt <= '0;
      found    <= 1'b0;
      slot     <= '0;
    end else if (state == ST_SCAN) begin
      if (issue) begin
        addr_cnt <= addr_cnt + CW'(1);
      end
      if (hit_now) begin
        found <= 1'b1;
        slot  <= rd_slot;
      end
    end
    if (issue) begin
      rd_slot <= addr_cnt;
    end
    if (state == ST_FIN) begin
      add_ok <= 1'b0;
    end else begin
      add_ok <= (op == FUNC_ADD) && !full_pre && !found && !hit_now;
    end
  end

  // value store: one write, one registered read
  always_ff @(posedge clk) begin
    if (state == ST_FIN && add_ok) begin
      value_store[fill_count[AW-1:0]] <= val;
    end
    if (issue) begin
      rd_data <= value_store[addr_cnt[AW-1:0]];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      added        <= add_ok_done;
      present      <= found;
      slot_index   <= SLOT_W'(slot);
      member_count <= COUNT_W'(fill_count);
      is_full      <= full_post;
      is_empty     <= (fill_count == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN) begin
      add_ok_done <= add_ok;
    end
  end

endmodule

// File: tb/sv/usvt_checker.sv
`timescale 1ns / 1ps
// Result checker for the unique value set table: shadow set, prediction and beat comparison.
module usvt_checker
  import usvt_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = DEF_STORE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [LIMIT_W-1:0]      cfg_data,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic                    func,
  input  logic [VAL_W-1:0]        element_value,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic                    added,
  input  logic                    present,
  input  logic [SLOT_W-1:0]       slot_index,
  input  logic [COUNT_W-1:0]      member_count,
  input  logic                    is_full,
  input  logic                    is_empty,
  input  logic                    drained,
  output int                      fail_count,
  output int                      pending
);

  typedef struct packed {
    logic               added;
    logic               present;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] count;
    logic               full;
    logic               empty;
  } set_result_t;

  logic [VAL_W-1:0]   shadow_vals [STORE_DEPTH];
  int unsigned        shadow_count;
  logic [LIMIT_W-1:0] shadow_limit;
  set_result_t        due_results [$];
  int                 mism_count;

  // scan in slot order, first hit wins; append only when not full and absent
  function automatic set_result_t predict_set_op(logic op, logic [VAL_W-1:0] v);
    set_result_t r;
    int unsigned lim;
    r   = '0;
    lim = (shadow_limit < STORE_DEPTH) ? shadow_limit : STORE_DEPTH;
    for (int unsigned i = 0; i < shadow_count; i++) begin
      if (shadow_vals[i] == v) begin
        r.present = 1'b1;
        r.slot    = SLOT_W'(i);
        break;
      end
    end
    if (op == FUNC_ADD && shadow_count < lim && !r.present) begin
      shadow_vals[shadow_count] = v;
      shadow_count++;
      r.added = 1'b1;
    end
    r.count = COUNT_W'(shadow_count);
    r.full  = (shadow_count >= lim);
    r.empty = (shadow_count == 0);
    return r;
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mism_count++;
      if (mism_count <= 10)
        $display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    set_result_t want;
    if (rst) begin
      shadow_count = 0;
      shadow_limit = CAPACITY_RESET;
      due_results.delete();
      mism_count   = 0;
    end else begin
      if (cfg_valid && cfg_ready)
        shadow_limit = cfg_data;
      if (in_valid && !in_stall)
        due_results.push_back(predict_set_op(func, element_value));
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          mism_count++;
          if (mism_count <= 10)
            $display("%0t: result beat with no request outstanding", $time);
        end else begin
          want = due_results.pop_front();
          compare_field("added", 32'(want.added), 32'(added));
          compare_field("present", 32'(want.present), 32'(present));
          compare_field("slot_index", 32'(want.slot), 32'(slot_index));
          compare_field("member_count", 32'(want.count), 32'(member_count));
          compare_field("is_full", 32'(want.full), 32'(is_full));
          compare_field("is_empty", 32'(want.empty), 32'(is_empty));
        end
      end
    end
    pending    <= due_results.size();
    fail_count <= mism_count + (drained ? due_results.size() : 0);
  end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the unique value set table: clock, reset, stimulus and verdict.
module tb_top
  import usvt_pkg::*;
();

  logic                clk;
  logic                rst;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [LIMIT_W-1:0]  cfg_data;
  logic                in_valid;
  logic                in_stall;
  logic                func;
  logic [VAL_W-1:0]    element_value;
  logic                out_valid;
  logic                out_stall;
  logic                added;
  logic                present;
  logic [SLOT_W-1:0]   slot_index;
  logic [COUNT_W-1:0]  member_count;
  logic                is_full;
  logic                is_empty;

  logic                drained;
  int                  fail_count;
  int                  pending;

  // traffic shaping: idle_on enables gaps/stalls, hold_go asks for one long hold-off
  logic                idle_on;
  logic                hold_go;
  logic                hold_done;
  int unsigned         hold_left;
  int unsigned         run_left;

  // every value offered in an add beat, for lookups and duplicate adds
  logic [VAL_W-1:0]    offered_vals [$];

  // capacity per random phase: grows the set in steps, drops below the count,
  // then goes past the store depth; last phase runs without idling
  localparam int NUM_PHASES = 10;
  localparam int PHASE_BEATS = 178;
  localparam int unsigned PHASE_CAPS [NUM_PHASES] = '{3, 12, 0, 30, 45, 64, 1, 127, 100, 64};

  initial clk = 1'b0;
  always #1 clk = ~clk;

  unique_value_set_table_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .func          (func),
    .element_value (element_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .added         (added),
    .present       (present),
    .slot_index    (slot_index),
    .member_count  (member_count),
    .is_full       (is_full),
    .is_empty      (is_empty)
  );

  usvt_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .func          (func),
    .element_value (element_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .added         (added),
    .present       (present),
    .slot_index    (slot_index),
    .member_count  (member_count),
    .is_full       (is_full),
    .is_empty      (is_empty),
    .drained       (drained),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  // Result side. Alternates free runs and stall bursts while idling is on.
  // The long hold-off is counted here, one time only, so that the block
  // backs up and has to stall its input beats.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
      run_left  <= 0;
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_go && !hold_done) begin
      hold_left <= 400;
      hold_done <= 1'b1;
      out_stall <= 1'b1;
    end else if (!idle_on) begin
      out_stall <= 1'b0;
    end else if (run_left != 0) begin
      run_left <= run_left - 1;
    end else if ($urandom_range(0, 2) == 0) begin
      run_left  <= $urandom_range(0, 11);
      out_stall <= 1'b1;
    end else begin
      run_left  <= $urandom_range(0, 39);
      out_stall <= 1'b0;
    end
  end

  // Offer one input beat; hold it until the block takes it.
  task automatic send_beat(logic f, logic [VAL_W-1:0] v);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    func          <= f;
    element_value <= v;
    if (f == FUNC_ADD)
      offered_vals.push_back(v);
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait until every request has its result.
  // The first edge lets the last accepted beat reach the pending count.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] lim);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= lim;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mix of earlier values (hits and duplicates), extremes and fresh randoms.
  function automatic logic [VAL_W-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40 && offered_vals.size() != 0)
      return offered_vals[$urandom_range(0, offered_vals.size() - 1)];
    if (roll < 50) begin
      case ($urandom_range(0, 4))
        0:       return 32'h8000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return 32'hFFFF_FFFF;
        3:       return 32'h0000_0001;
        default: return 32'h0000_0000;
      endcase
    end
    return VAL_W'($urandom);
  endfunction

  task automatic run_mixed(int beats, logic with_hold);
    logic op;
    for (int n = 0; n < beats; n++) begin
      if (with_hold && n == beats / 2)
        hold_go <= 1'b1;
      op = ($urandom_range(0, 1) == 0) ? FUNC_ADD : FUNC_LOOKUP;
      send_beat(op, pick_value());
    end
  endtask

  initial begin
    rst           <= 1'b1;
    cfg_valid     <= 1'b0;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    func          <= FUNC_ADD;
    element_value <= '0;
    drained       <= 1'b0;
    idle_on       <= 1'b1;
    hold_go       <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: empty-set lookup, extremes added, duplicate add, hit and miss
    send_beat(FUNC_LOOKUP, 32'h0000_0000);
    send_beat(FUNC_ADD,    32'h8000_0000);
    send_beat(FUNC_ADD,    32'h7FFF_FFFF);
    send_beat(FUNC_ADD,    32'h0000_0000);
    send_beat(FUNC_ADD,    32'hFFFF_FFFF);
    send_beat(FUNC_ADD,    32'h8000_0000);
    send_beat(FUNC_LOOKUP, 32'hFFFF_FFFF);
    send_beat(FUNC_LOOKUP, 32'h0000_0001);

    // limit lowered to zero under a populated set: reads full, adds refused
    write_limit(LIMIT_W'(0));
    send_beat(FUNC_ADD,    32'h0000_0005);
    send_beat(FUNC_LOOKUP, 32'h0000_0000);
    send_beat(FUNC_ADD,    32'h0000_0000);

    // fill exactly to the limit, then add to a full set (absent value)
    write_limit(LIMIT_W'(5));
    send_beat(FUNC_ADD,    32'h0000_0005);
    send_beat(FUNC_ADD,    32'h0000_0006);
    send_beat(FUNC_LOOKUP, 32'h0000_0005);

    // limit above store depth
    write_limit(LIMIT_W'(127));
    send_beat(FUNC_ADD,    32'h0000_0006);
    send_beat(FUNC_LOOKUP, 32'h0000_0006);

    // random phases; long hold-off in the fourth, traffic without idling in the last
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_limit(LIMIT_W'(PHASE_CAPS[p]));
      if (p == NUM_PHASES - 1)
        idle_on <= 1'b0;
      run_mixed(PHASE_BEATS, p == 3);
    end

    wait_idle();
    repeat (100) @(posedge clk);
    drained <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // watchdog: several times the slowest legal run
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
